>>> src/wwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwr_pkg
// Shared types and constants of the weighted window retarget block.
// ----------------------------------------------------------------------------
package wwr_pkg;

	localparam int WinW = 8;
	localparam int KW = 32;
	localparam int LimbW = 64;
	localparam int TargW = 256;
	localparam int CfgIdxW = 3;
	localparam int DefMaxWindow = 128;

	localparam logic [CfgIdxW-1:0] CFG_WINDOW = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_WEIGHT = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT0 = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT1 = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT2 = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_LIMIT3 = 3'd5;

	localparam logic [WinW-1:0] RST_WINDOW = 8'd45;
	localparam logic [KW-1:0] RST_WEIGHT = 32'd1;
	localparam logic [TargW-1:0] RST_LIMIT = {64'd2251799813685247, {192{1'b1}}};

	typedef struct packed {
		logic [WinW-1:0] window_size;
		logic [KW-1:0] weight_factor;
		logic [TargW-1:0] limit;
	} cfg_regs_t;

endpackage
`default_nettype wire

>>> src/wwr_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wwr_cfg
// Configuration register file, written through a valid request port.
// ----------------------------------------------------------------------------
module wwr_cfg import wwr_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic [CfgIdxW-1:0] cfg_index,
	input wire logic [LimbW-1:0] cfg_data,
	output cfg_regs_t regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.window_size <= RST_WINDOW;
			regs_q.weight_factor <= RST_WEIGHT;
			regs_q.limit <= RST_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WINDOW: regs_q.window_size <= cfg_data[WinW-1:0];
				CFG_WEIGHT: regs_q.weight_factor <= cfg_data[KW-1:0];
				CFG_LIMIT0: regs_q.limit[63:0] <= cfg_data;
				CFG_LIMIT1: regs_q.limit[127:64] <= cfg_data;
				CFG_LIMIT2: regs_q.limit[191:128] <= cfg_data;
				CFG_LIMIT3: regs_q.limit[255:192] <= cfg_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule
`default_nettype wire

>>> src/weighted_window_retarget.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_window_retarget
// Linearly weighted moving-average retarget over block records, newest first.
// ----------------------------------------------------------------------------
// A record is taken when start is high and busy is low; busy stays high until
// the record is fully processed. A record inside the window runs through the
// bit-serial 256-bit divider (one quotient bit a cycle). A record that closes
// the window runs a two-step reciprocal divide by three, a 64-step shift-add
// multiply and a byte-wise normalize of up to 32 steps. A short-chain record
// skips the divider and normalizes the configured limit. Results appear on
// next_compact and window_short for one cycle with done high; the receiver
// cannot stall them. Configuration writes are always ready.
module weighted_window_retarget import wwr_pkg::*; #(
	parameter int MAX_WINDOW = DefMaxWindow
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [31:0] block_time,
	input wire logic [31:0] compact_target,
	input wire logic has_parent,
	output logic done,
	output logic [31:0] next_compact,
	output logic window_short,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CfgIdxW-1:0] cfg_index,
	input wire logic [LimbW-1:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NK = 4'd1;
	localparam logic [3:0] S_FLOOR = 4'd2;
	localparam logic [3:0] S_SEL = 4'd3;
	localparam logic [3:0] S_MUL = 4'd4;
	localparam logic [3:0] S_SAT = 4'd5;
	localparam logic [3:0] S_NORM = 4'd6;
	localparam logic [3:0] S_OUT = 4'd7;
	localparam logic [3:0] S_WSUM = 4'd8;
	localparam logic [3:0] S_ND = 4'd9;
	localparam logic [3:0] S_DEC = 4'd10;
	localparam logic [3:0] S_DIV = 4'd11;
	localparam logic [3:0] S_ADD = 4'd12;
	localparam logic [3:0] S_FDIV = 4'd13;

	localparam logic [WinW-1:0] MaxN = WinW'(MAX_WINDOW);

	// (2^20 - 1) / 3 and the reciprocal of 3 scaled by 2^22
	localparam logic [39:0] Third20 = 40'd349525;
	localparam logic [42:0] Recip3 = 43'd1398102;

	cfg_regs_t cfg;

	wwr_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.regs(cfg)
	);

	assign cfg_ready = 1'b1;

	logic [3:0] state_q;
	logic [31:0] time_q, comp_q;
	logic par_q;
	logic [39:0] nk_q;
	logic [39:0] fa_q;
	logic [20:0] fy_q;
	logic [47:0] d_q;
	logic [63:0] t_q;
	logic [320:0] p_q;
	logic [255:0] work_q;
	logic [48:0] rem_q;
	logic [7:0] cnt_q;
	logic [5:0] nb_q;
	logic short_q;
	logic [7:0] count_q;
	logic [31:0] prev_q;
	logic [63:0] wsum_q;
	logic [255:0] tsum_q;
	logic done_q;
	logic [31:0] nc_q;

	logic [WinW-1:0] n_w;
	assign n_w = (cfg.window_size > MaxN) ? MaxN : cfg.window_size;

	// divide by three: hi * (2^20 - 1) / 3 + (hi + lo) / 3
	logic [42:0] f_prod;
	assign f_prod = {22'd0, fy_q} * Recip3;

	// restoring divider step
	logic [48:0] d_r2;
	logic d_bit;
	assign d_r2 = {rem_q[47:0], work_q[255]};
	assign d_bit = (d_r2 >= {1'b0, d_q});

	// shift-add multiplier step
	logic [256:0] m_sum;
	assign m_sum = p_q[320:64] + {1'b0, (t_q[0] ? work_q : 256'd0)};

	// compact decode
	logic [7:0] dec_size;
	logic [255:0] dec_v;
	always_comb begin
		dec_size = comp_q[31:24];
		if (dec_size <= 8'd3)
			dec_v = {233'd0, comp_q[22:0] >> (5'(8) * 5'(2'(3 - dec_size[1:0])))};
		else if (dec_size >= 8'd35)
			dec_v = '0;
		else
			dec_v = {233'd0, comp_q[22:0]} << {dec_size - 8'd3, 3'd0};
	end

	// compact encode from normalized word
	logic [23:0] enc_m;
	logic [7:0] enc_size;
	always_comb begin
		enc_m = work_q[255:232];
		enc_size = {2'b00, nb_q};
		if (enc_m[23]) begin
			enc_m = enc_m >> 8;
			enc_size = enc_size + 8'd1;
		end
	end

	logic [63:0] solve_w;
	assign solve_w = {32'd0, prev_q} - {32'd0, time_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			prev_q <= '0;
			wsum_q <= '0;
			tsum_q <= '0;
			done_q <= 1'b0;
			short_q <= 1'b0;
			cnt_q <= '0;
			nb_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						time_q <= block_time;
						comp_q <= compact_target;
						par_q <= has_parent;
						state_q <= S_NK;
					end
				end
				S_NK: begin
					nk_q <= cfg.weight_factor * n_w;
					cnt_q <= '0;
					state_q <= (count_q >= n_w) ? S_FLOOR : S_WSUM;
				end
				S_FLOOR: begin
					fa_q <= {20'd0, nk_q[39:20]} * Third20;
					fy_q <= {1'b0, nk_q[39:20]} + {1'b0, nk_q[19:0]};
					state_q <= S_FDIV;
				end
				S_FDIV: begin
					nk_q <= fa_q + {19'd0, f_prod[42:22]};
					state_q <= S_SEL;
				end
				S_SEL: begin
					if (wsum_q[63] || wsum_q < {24'd0, nk_q})
						t_q <= {24'd0, nk_q};
					else
						t_q <= wsum_q;
					work_q <= tsum_q;
					p_q <= '0;
					cnt_q <= '0;
					short_q <= 1'b0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					p_q <= {1'b0, m_sum, p_q[63:1]};
					t_q <= t_q >> 1;
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd63)
						state_q <= S_SAT;
				end
				S_SAT: begin
					if ((|p_q[320:256]) || (p_q[255:0] > cfg.limit))
						work_q <= cfg.limit;
					else
						work_q <= p_q[255:0];
					nb_q <= 6'd32;
					state_q <= S_NORM;
				end
				S_NORM: begin
					if ((|work_q[255:248]) || nb_q == 6'd0) begin
						state_q <= S_OUT;
					end else begin
						work_q <= {work_q[247:0], 8'd0};
						nb_q <= nb_q - 6'd1;
					end
				end
				S_OUT: begin
					done_q <= 1'b1;
					nc_q <= {enc_size, enc_m};
					count_q <= '0;
					prev_q <= '0;
					wsum_q <= '0;
					tsum_q <= '0;
					state_q <= S_IDLE;
				end
				S_WSUM: begin
					if (count_q != 8'd0)
						wsum_q <= wsum_q + 64'(solve_w * (n_w - count_q));
					if (!par_q) begin
						work_q <= cfg.limit;
						nb_q <= 6'd32;
						short_q <= 1'b1;
						state_q <= S_NORM;
					end else begin
						state_q <= S_ND;
					end
				end
				S_ND: begin
					d_q <= nk_q * n_w;
					state_q <= S_DEC;
				end
				S_DEC: begin
					work_q <= dec_v;
					rem_q <= '0;
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= d_bit ? (d_r2 - {1'b0, d_q}) : d_r2;
					work_q <= {work_q[254:0], d_bit};
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == 8'd255)
						state_q <= S_ADD;
				end
				S_ADD: begin
					tsum_q <= tsum_q + work_q;
					prev_q <= time_q;
					count_q <= count_q + 8'd1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign next_compact = nc_q;
	assign window_short = short_q;

endmodule
`default_nettype wire
